@@ hdl/ctpf_pkg.sv @@
// ----------------------------------------------------------------------------
// ctpf_pkg
// shared types, codes and helpers of the two-peak finder
// ----------------------------------------------------------------------------
package ctpf_pkg;

   // field widths fixed by the interface
   localparam int SAMPLE_W    = 16;
   localparam int POS_W       = 14;
   localparam int INDEX_W     = 14;
   localparam int TRACE_W     = 2;
   localparam int TRACES      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_SAMPLE_W = 15;
   localparam int CSR_BASE_W  = 12;

   // largest call position that a load may store
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [TRACE_W-1:0] trace_id_type;
   typedef logic [TRACES-1:0][SAMPLE_W-1:0] sample_quad_type;

   // request codes
   typedef enum logic [1:0] {
      REQ_LOAD_SAMPLE = 2'd0,
      REQ_LOAD_CALL   = 2'd1,
      REQ_QUERY       = 2'd2
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_COUNT = 2'd0,
      CSR_BASE_COUNT   = 2'd1
   } csr_index_type;

   // query sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALL_PREV,
      ST_CALL_NEXT,
      ST_TRACE_CENTRE,
      ST_TRACE_START,
      ST_TRACE_END,
      ST_LATCH_END,
      ST_RESULT
   } ctpf_state_type;

   // one result beat
   typedef struct packed {
      logic         has_two_peaks;
      trace_id_type first_trace;
      sample_type   first_value;
      trace_id_type second_trace;
      sample_type   second_value;
      logic         position_error;
   } ctpf_result_type;

   // result with no peaks reported
   function automatic ctpf_result_type no_peak_result(input logic perr);
      ctpf_result_type r;
      r.has_two_peaks  = 1'b0;
      r.first_trace    = trace_id_type'(0);
      r.first_value    = '0;
      r.second_trace   = trace_id_type'(1);
      r.second_value   = '0;
      r.position_error = perr;
      return r;
   endfunction

endpackage

@@ hdl/ctpf_ram.sv @@
// ----------------------------------------------------------------------------
// ctpf_ram
// single-port-write, single-port-read synchronous memory, registered read
// ----------------------------------------------------------------------------
module ctpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/ctpf_peak_select.sv @@
// ----------------------------------------------------------------------------
// ctpf_peak_select
// peak test per trace, ranking of the two strongest peaks and top-two check
// ----------------------------------------------------------------------------
module ctpf_peak_select (
   input  ctpf_pkg::sample_quad_type centre_val,
   input  ctpf_pkg::sample_quad_type lead_val,
   input  ctpf_pkg::sample_quad_type tail_val,
   output ctpf_pkg::ctpf_result_type result
);
   import ctpf_pkg::*;

   logic [TRACES-1:0] peak;
   logic [2:0]        peak_num;
   trace_id_type      b1, b2, i0;
   sample_type        v1, v2, s0, s1;
   logic              f1, f2, g0, g1;

   // local peak: neither edge sample above the centre
   always_comb begin
      for (int t = 0; t < TRACES; t++) begin
         peak[t] = (lead_val[t] <= centre_val[t]) && (tail_val[t] <= centre_val[t]);
      end
      peak_num = 3'($countones(peak));
   end

   // strongest peak, earlier trace wins ties
   always_comb begin
      b1 = '0;
      v1 = '0;
      f1 = 1'b0;
      for (int t = 0; t < TRACES; t++) begin
         if (peak[t] && (!f1 || centre_val[t] > v1)) begin
            b1 = trace_id_type'(t);
            v1 = centre_val[t];
            f1 = 1'b1;
         end
      end
   end

   // second peak among the remaining ones
   always_comb begin
      b2 = '0;
      v2 = '0;
      f2 = 1'b0;
      for (int t = 0; t < TRACES; t++) begin
         if (peak[t] && (trace_id_type'(t) != b1) && (!f2 || centre_val[t] > v2)) begin
            b2 = trace_id_type'(t);
            v2 = centre_val[t];
            f2 = 1'b1;
         end
      end
   end

   // largest and second largest centre values over all traces
   always_comb begin
      i0 = '0;
      s0 = '0;
      g0 = 1'b0;
      for (int t = 0; t < TRACES; t++) begin
         if (!g0 || centre_val[t] > s0) begin
            i0 = trace_id_type'(t);
            s0 = centre_val[t];
            g0 = 1'b1;
         end
      end
      s1 = '0;
      g1 = 1'b0;
      for (int t = 0; t < TRACES; t++) begin
         if ((trace_id_type'(t) != i0) && (!g1 || centre_val[t] > s1)) begin
            s1 = centre_val[t];
            g1 = 1'b1;
         end
      end
   end

   // report the pair unless too few peaks or both ranks disagree
   always_comb begin
      if ((peak_num < 3'd2) || ((v1 != s0) && (v2 != s1))) begin
         result = no_peak_result(1'b0);
      end else begin
         result.has_two_peaks  = 1'b1;
         result.first_trace    = b1;
         result.first_value    = v1;
         result.second_trace   = b2;
         result.second_value   = v2;
         result.position_error = 1'b0;
      end
   end

endmodule

@@ hdl/chromatogram_two_peak_finder.sv @@
// ----------------------------------------------------------------------------
// chromatogram_two_peak_finder
// four-trace chromatogram store with a two-peak query at a base position
// ----------------------------------------------------------------------------
// usage
//   request beats are taken when start is high and busy is low. req_type
//   selects a sample load (into trace req_trace_sel), a base-call load or a
//   peak query at base position req_index; code 3 is dropped.
//   loads never raise busy, so a beat may follow each cycle. a query raises
//   busy and answers with one rsp beat, marked by rsp_strobe for exactly
//   one cycle, after three reads of the call table, three reads of the
//   four trace banks in parallel, an end sample latch and the ranking stage.
//   the single read port of each memory makes these reads run one after
//   another. busy stays high through these steps, so a query is taken only
//   once the one before is through. a query at a position not below
//   base_count (capped at MAX_BASES) answers in the next cycle with
//   position_error set and leaves busy low. the rsp side cannot stall; a new
//   beat is taken while a result is shown. csr writes (index 0 sample_count,
//   index 1 base_count) are always ready and are to be issued only while the
//   block is idle. reset clears the sequencer and both counts; memory
//   contents are kept and every entry must be loaded before a query reads it.
// ----------------------------------------------------------------------------
module chromatogram_two_peak_finder #(
   parameter int MAX_SAMPLES = 16384,
   parameter int MAX_BASES   = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_type,
   input  logic [ctpf_pkg::TRACE_W-1:0]         req_trace_sel,
   input  logic [ctpf_pkg::INDEX_W-1:0]         req_index,
   input  logic [ctpf_pkg::SAMPLE_W-1:0]        req_value,
   output logic                                 rsp_strobe,
   output logic                                 rsp_has_two_peaks,
   output logic [ctpf_pkg::TRACE_W-1:0]         rsp_first_trace,
   output logic [ctpf_pkg::SAMPLE_W-1:0]        rsp_first_value,
   output logic [ctpf_pkg::TRACE_W-1:0]         rsp_second_trace,
   output logic [ctpf_pkg::SAMPLE_W-1:0]        rsp_second_value,
   output logic                                 rsp_position_error,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ctpf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ctpf_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ctpf_pkg::*;

   localparam int SAW = $clog2(MAX_SAMPLES);
   localparam int CAW = $clog2(MAX_BASES);
   localparam int NSW = $clog2(MAX_SAMPLES + 1);
   localparam int NBW = $clog2(MAX_BASES + 1);

   // control bundle from the sequencer
   typedef struct packed {
      logic busy;
      logic latch_cur;
      logic latch_prev;
      logic latch_next;
      logic latch_centre;
      logic latch_lead;
      logic latch_tail;
      logic emit;
   } seq_ctrl_type;

   ctpf_state_type          state_ff, state_in;
   seq_ctrl_type            ctrl;
   logic [CSR_SAMPLE_W-1:0] sample_count_ff, sample_count_in;
   logic [CSR_BASE_W-1:0]   base_count_ff, base_count_in;
   logic [CAW-1:0]          idx_ff, idx_in;
   pos_type                 cur_ff, prev_ff, next_ff;
   sample_quad_type         centre_ff, lead_ff, tail_ff;
   ctpf_result_type         rsp_ff, rsp_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;

   logic [NSW-1:0]          eff_samples;
   logic [NSW-1:0]          last_sample;
   logic [NBW-1:0]          eff_bases;
   logic                    samples_empty;
   logic                    accept;
   logic                    query_accept;
   logic                    query_bad;
   logic                    sample_we;
   logic                    call_we;
   pos_type                 call_wr_data;
   logic [CAW-1:0]          prev_idx, next_idx;
   logic [CAW-1:0]          call_rd_addr;
   pos_type                 call_rd_data;
   logic [SAW-1:0]          centre_addr, lead_addr, tail_addr, trace_rd_addr;
   sample_quad_type         bank_rd, bank_val;
   ctpf_result_type         peak_result;

   // saturate a sample address to the last valid sample
   function automatic logic [SAW-1:0] sat_addr(input pos_type a, input logic [NSW-1:0] last);
      if (32'(a) > 32'(last)) begin
         return SAW'(last);
      end
      return SAW'(a);
   endfunction

   // halfway point toward a neighbour call, truncating toward the current call
   function automatic pos_type halfway(input pos_type c, input pos_type nb);
      if (nb >= c) begin
         return c + ((nb - c) >> 1);
      end
      return c - ((c - nb) >> 1);
   endfunction

   // effective counts
   always_comb begin
      eff_samples = (32'(sample_count_ff) < 32'(MAX_SAMPLES)) ?
                    NSW'(sample_count_ff) : NSW'(MAX_SAMPLES);
      eff_bases   = (32'(base_count_ff) < 32'(MAX_BASES)) ?
                    NBW'(base_count_ff) : NBW'(MAX_BASES);
      last_sample   = eff_samples - NSW'(1);
      samples_empty = (eff_samples == '0);
   end

   // request decode
   assign accept       = start && !busy;
   assign sample_we    = accept && (req_type == REQ_LOAD_SAMPLE) &&
                         (32'(req_index) < 32'(MAX_SAMPLES));
   assign call_we      = accept && (req_type == REQ_LOAD_CALL) &&
                         (32'(req_index) < 32'(MAX_BASES));
   assign call_wr_data = (req_value > SAMPLE_W'(POS_MAX)) ? POS_MAX : POS_W'(req_value);
   assign query_accept = accept && (req_type == REQ_QUERY);
   assign query_bad    = (eff_bases == '0) || (32'(req_index) >= 32'(eff_bases));

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      sample_count_in = sample_count_ff;
      base_count_in   = base_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_in = CSR_SAMPLE_W'(csr_data);
            CSR_BASE_COUNT:   base_count_in   = CSR_BASE_W'(csr_data);
            default: ;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_accept && !query_bad) begin
               state_in = ST_CALL_PREV;
            end
         end
         ST_CALL_PREV:    state_in = ST_CALL_NEXT;
         ST_CALL_NEXT:    state_in = ST_TRACE_CENTRE;
         ST_TRACE_CENTRE: state_in = ST_TRACE_START;
         ST_TRACE_START:  state_in = ST_TRACE_END;
         ST_TRACE_END:    state_in = ST_LATCH_END;
         ST_LATCH_END:    state_in = ST_RESULT;
         ST_RESULT:       state_in = ST_IDLE;
         default:         state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:         ctrl.busy = 1'b0;
         ST_CALL_PREV:    begin ctrl.busy = 1'b1; ctrl.latch_cur    = 1'b1; end
         ST_CALL_NEXT:    begin ctrl.busy = 1'b1; ctrl.latch_prev   = 1'b1; end
         ST_TRACE_CENTRE: begin ctrl.busy = 1'b1; ctrl.latch_next   = 1'b1; end
         ST_TRACE_START:  begin ctrl.busy = 1'b1; ctrl.latch_centre = 1'b1; end
         ST_TRACE_END:    begin ctrl.busy = 1'b1; ctrl.latch_lead   = 1'b1; end
         ST_LATCH_END:    begin ctrl.busy = 1'b1; ctrl.latch_tail   = 1'b1; end
         ST_RESULT:       begin ctrl.busy = 1'b1; ctrl.emit         = 1'b1; end
         default:         ctrl = '0;
      endcase
   end

   assign busy = ctrl.busy;

   // neighbour call indexes, clamped at the row edges
   assign idx_in   = query_accept ? CAW'(req_index) : idx_ff;
   assign prev_idx = (idx_ff == '0) ? idx_ff : idx_ff - CAW'(1);
   assign next_idx = (32'(idx_ff) == 32'(eff_bases) - 32'd1) ? idx_ff : idx_ff + CAW'(1);

   // call table read address
   always_comb begin
      case (state_ff)
         ST_CALL_PREV: call_rd_addr = prev_idx;
         ST_CALL_NEXT: call_rd_addr = next_idx;
         default:      call_rd_addr = CAW'(req_index);
      endcase
   end

   ctpf_ram #(
      .WIDTH (POS_W),
      .DEPTH (MAX_BASES)
   ) u_call_table (
      .clock   (clock),
      .wr_en   (call_we),
      .wr_addr (CAW'(req_index)),
      .wr_data (call_wr_data),
      .rd_addr (call_rd_addr),
      .rd_data (call_rd_data)
   );

   // trace sample addresses
   always_comb begin
      centre_addr = sat_addr(cur_ff, last_sample);
      lead_addr   = (prev_ff == cur_ff) ? SAW'(0) : sat_addr(halfway(cur_ff, prev_ff), last_sample);
      tail_addr   = (next_ff == cur_ff) ? SAW'(last_sample) :
                    sat_addr(halfway(cur_ff, next_ff), last_sample);
      case (state_ff)
         ST_TRACE_START: trace_rd_addr = lead_addr;
         ST_TRACE_END:   trace_rd_addr = tail_addr;
         default:        trace_rd_addr = centre_addr;
      endcase
   end

   // four trace banks read in parallel
   for (genvar b = 0; b < TRACES; b++) begin : g_bank
      ctpf_ram #(
         .WIDTH (SAMPLE_W),
         .DEPTH (MAX_SAMPLES)
      ) u_trace_bank (
         .clock   (clock),
         .wr_en   (sample_we && (req_trace_sel == TRACE_W'(b))),
         .wr_addr (SAW'(req_index)),
         .wr_data (req_value),
         .rd_addr (trace_rd_addr),
         .rd_data (bank_rd[b])
      );
   end

   // with no valid samples every read gives zero
   assign bank_val = samples_empty ? '0 : bank_rd;

   ctpf_peak_select u_peak_select (
      .centre_val (centre_ff),
      .lead_val   (lead_ff),
      .tail_val   (tail_ff),
      .result     (peak_result)
   );

   // result beat
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      if (ctrl.emit) begin
         rsp_in        = peak_result;
         rsp_strobe_in = 1'b1;
      end else if (query_accept && query_bad) begin
         rsp_in        = no_peak_result(1'b1);
         rsp_strobe_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sample_count_ff <= '0;
         base_count_ff   <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sample_count_ff <= sample_count_in;
         base_count_ff   <= base_count_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
      if (ctrl.latch_cur)    cur_ff    <= call_rd_data;
      if (ctrl.latch_prev)   prev_ff   <= call_rd_data;
      if (ctrl.latch_next)   next_ff   <= call_rd_data;
      if (ctrl.latch_centre) centre_ff <= bank_val;
      if (ctrl.latch_lead)   lead_ff   <= bank_val;
      if (ctrl.latch_tail)   tail_ff   <= bank_val;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_has_two_peaks  = rsp_ff.has_two_peaks;
   assign rsp_first_trace    = rsp_ff.first_trace;
   assign rsp_first_value    = rsp_ff.first_value;
   assign rsp_second_trace   = rsp_ff.second_trace;
   assign rsp_second_value   = rsp_ff.second_value;
   assign rsp_position_error = rsp_ff.position_error;

endmodule

@@ hdl/ctpf_checker.sv @@
// ----------------------------------------------------------------------------
// ctpf_checker
// port-level checks of the two-peak finder, bound to the top level
// ----------------------------------------------------------------------------
module ctpf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [1:0]                    req_type,
   input logic                          rsp_strobe,
   input logic                          rsp_has_two_peaks,
   input logic [ctpf_pkg::TRACE_W-1:0]  rsp_first_trace,
   input logic [ctpf_pkg::SAMPLE_W-1:0] rsp_first_value,
   input logic [ctpf_pkg::TRACE_W-1:0]  rsp_second_trace,
   input logic [ctpf_pkg::SAMPLE_W-1:0] rsp_second_value,
   input logic                          rsp_position_error
);
   import ctpf_pkg::*;

   // an accepted query either starts work or answers at once
   a_query_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_QUERY)) |=> (busy || rsp_strobe))
      else $error("query accepted without work or answer");

   // a load beat never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == REQ_LOAD_SAMPLE || req_type == REQ_LOAD_CALL))
      |=> !rsp_strobe)
      else $error("result beat after a load");

   // a full answer only ends a busy query
   a_answer_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_position_error) |-> $past(busy))
      else $error("peak answer without a running query");

   // no-peak beats carry the fixed filler fields
   a_no_peak_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_has_two_peaks) |->
      (rsp_first_trace == '0 && rsp_first_value == '0 &&
       rsp_second_trace == TRACE_W'(1) && rsp_second_value == '0))
      else $error("no-peak result with stray fields");

   // strongest peak ranks at or above the second, on another trace, with no position error
   a_peak_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_has_two_peaks) |->
      (rsp_first_value >= rsp_second_value && !rsp_position_error &&
       rsp_first_trace != rsp_second_trace))
      else $error("peak pair out of order");

endmodule

bind chromatogram_two_peak_finder ctpf_checker u_ctpf_checker (.*);

@@ tb/sv/chromatogram_two_peak_finder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chromatogram_two_peak_finder_tb
// self-checking bench for the four-trace two-peak finder
// ----------------------------------------------------------------------------
// loads trace samples and base calls, then queries base positions. A tracker
// class keeps its own copy of both memories and of the two count registers,
// works out the answer of every accepted query and checks each rsp beat
// against the oldest answer still awaited. Queries only read entries that
// were loaded before: missing ones are loaded first. Register settings change
// between phases while the block is idle, and the request side idles at
// several rates.
// ----------------------------------------------------------------------------
module chromatogram_two_peak_finder_tb;
   import ctpf_pkg::*;

   localparam int SAMPLE_DEPTH = 16384;
   localparam int CALL_DEPTH   = 2048;
   localparam int POS_LIMIT    = 16383;
   localparam int INDEX_LIMIT  = 16383;
   localparam int VALUE_LIMIT  = 65535;
   localparam int PHASE_BEATS  = 80;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;

   // codes the package leaves unnamed
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   // tracker of memory contents, counts and awaited answers
   class two_peak_tracker;
      sample_type trace_mem [TRACES][SAMPLE_DEPTH];
      bit trace_loaded [TRACES][SAMPLE_DEPTH];
      pos_type call_mem [CALL_DEPTH];
      bit call_loaded [CALL_DEPTH];
      logic [CSR_SAMPLE_W-1:0] sample_cnt;
      logic [CSR_BASE_W-1:0] base_cnt;
      ctpf_result_type awaited_answers [$];
      int failures;
      int queries;
      int pair_hits;
      int range_flags;

      function new();
         sample_cnt = '0;
         base_cnt = '0;
         failures = 0;
         queries = 0;
         pair_hits = 0;
         range_flags = 0;
      endfunction

      function int sample_limit();
         return (int'(sample_cnt) < SAMPLE_DEPTH) ? int'(sample_cnt) : SAMPLE_DEPTH;
      endfunction

      function int base_limit();
         return (int'(base_cnt) < CALL_DEPTH) ? int'(base_cnt) : CALL_DEPTH;
      endfunction

      // saturate a sample address into the valid range (needs samples)
      function int clip_addr(int addr);
         int n;
         n = sample_limit();
         if (addr < 0) return 0;
         if (addr > n - 1) return n - 1;
         return addr;
      endfunction

      function int read_trace(int tr, int addr);
         if (sample_limit() == 0) return 0;
         return int'(trace_mem[tr][clip_addr(addr)]);
      endfunction

      // centre, start and end sample addresses of a query, before saturation
      function void query_window(input int idx, output int c_addr, output int s_addr,
                                 output int e_addr);
         int nb, cur, prev, nxt;
         nb = base_limit();
         cur = int'(call_mem[idx]);
         prev = int'(call_mem[(idx != 0) ? idx - 1 : idx]);
         nxt = int'(call_mem[(idx != nb - 1) ? idx + 1 : idx]);
         c_addr = cur;
         s_addr = (prev == cur) ? 0 : cur - (cur - prev) / 2;
         e_addr = (nxt == cur) ? sample_limit() - 1 : cur + (nxt - cur) / 2;
      endfunction

      function ctpf_result_type predict_peaks(int idx);
         ctpf_result_type r;
         int nb, c_addr, s_addr, e_addr, npk, b1, b2, i, j, v, tr;
         int centre [4];
         int ranked [4];
         int pk_tr [4];
         int pk_val [4];
         r = '0;
         r.second_trace = trace_id_type'(1);
         queries++;
         nb = base_limit();
         if (nb == 0 || idx >= nb) begin
            r.position_error = 1'b1;
            range_flags++;
            return r;
         end
         query_window(idx, c_addr, s_addr, e_addr);
         // local peak test per trace
         npk = 0;
         for (tr = 0; tr < TRACES; tr++) begin
            centre[tr] = read_trace(tr, c_addr);
            if (read_trace(tr, s_addr) <= centre[tr] && read_trace(tr, e_addr) <= centre[tr]) begin
               pk_tr[npk] = tr;
               pk_val[npk] = centre[tr];
               npk++;
            end
         end
         if (npk < 2) return r;
         // strongest two peaks, earlier trace wins ties
         b1 = 0;
         for (i = 1; i < npk; i++)
            if (pk_val[i] > pk_val[b1]) b1 = i;
         b2 = (b1 == 0) ? 1 : 0;
         for (i = 0; i < npk; i++)
            if (i != b1 && pk_val[i] > pk_val[b2]) b2 = i;
         // centre values in descending order
         for (i = 0; i < 4; i++) ranked[i] = centre[i];
         for (i = 1; i < 4; i++) begin
            v = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] < v) begin
               ranked[j] = ranked[j-1];
               j--;
            end
            ranked[j] = v;
         end
         // pair dropped when neither peak agrees with the top centre values
         if (pk_val[b1] != ranked[0] && pk_val[b2] != ranked[1]) return r;
         r.has_two_peaks = 1'b1;
         r.first_trace = trace_id_type'(pk_tr[b1]);
         r.first_value = sample_type'(pk_val[b1]);
         r.second_trace = trace_id_type'(pk_tr[b2]);
         r.second_value = sample_type'(pk_val[b2]);
         pair_hits++;
         return r;
      endfunction

      // accepted request beat
      function void note_request(logic [1:0] kind, trace_id_type tsel,
                                 logic [INDEX_W-1:0] idx, sample_type val);
         case (kind)
            REQ_LOAD_SAMPLE: begin
               if (idx < SAMPLE_DEPTH) begin
                  trace_mem[tsel][idx] = val;
                  trace_loaded[tsel][idx] = 1'b1;
               end
            end
            REQ_LOAD_CALL: begin
               if (idx < CALL_DEPTH) begin
                  call_mem[idx] = (val > POS_MAX) ? POS_MAX : val[POS_W-1:0];
                  call_loaded[idx] = 1'b1;
               end
            end
            REQ_QUERY: awaited_answers.push_back(predict_peaks(int'(idx)));
            default: ;
         endcase
      endfunction

      function void note_config(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SAMPLE_COUNT: sample_cnt = data[CSR_SAMPLE_W-1:0];
            CSR_BASE_COUNT: base_cnt = data[CSR_BASE_W-1:0];
            default: ;
         endcase
      endfunction

      function int field_differs(string name, int want, int got);
         if (want == got) return 0;
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      endfunction

      // result beat against the oldest awaited answer
      function void check_answer(ctpf_result_type got);
         ctpf_result_type want;
         if (awaited_answers.size() == 0) begin
            $error("result beat with no query outstanding");
            failures++;
            return;
         end
         want = awaited_answers.pop_front();
         failures += field_differs("has_two_peaks", want.has_two_peaks, got.has_two_peaks);
         failures += field_differs("first_trace", want.first_trace, got.first_trace);
         failures += field_differs("first_value", want.first_value, got.first_value);
         failures += field_differs("second_trace", want.second_trace, got.second_trace);
         failures += field_differs("second_value", want.second_value, got.second_value);
         failures += field_differs("position_error", want.position_error,
                                   got.position_error);
      endfunction

      function void close_out();
         if (awaited_answers.size() != 0) begin
            $error("%0d queries never answered", awaited_answers.size());
            failures += awaited_answers.size();
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_type;
   trace_id_type req_trace_sel;
   logic [INDEX_W-1:0] req_index;
   sample_type req_value;
   logic rsp_strobe;
   logic rsp_has_two_peaks;
   trace_id_type rsp_first_trace;
   sample_type rsp_first_value;
   trace_id_type rsp_second_trace;
   sample_type rsp_second_value;
   logic rsp_position_error;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   two_peak_tracker sb = new();
   ctpf_result_type seen_answer;
   int idle_pct = 0;
   int beats_sent = 0;
   int settings_used = 0;
   int cycle_count = 0;

   chromatogram_two_peak_finder #(
      .MAX_SAMPLES(SAMPLE_DEPTH),
      .MAX_BASES(CALL_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_trace_sel(req_trace_sel),
      .req_index(req_index),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_has_two_peaks(rsp_has_two_peaks),
      .rsp_first_trace(rsp_first_trace),
      .rsp_first_value(rsp_first_value),
      .rsp_second_trace(rsp_second_trace),
      .rsp_second_value(rsp_second_value),
      .rsp_position_error(rsp_position_error),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result beats
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen_answer.has_two_peaks = rsp_has_two_peaks;
         seen_answer.first_trace = rsp_first_trace;
         seen_answer.first_value = rsp_first_value;
         seen_answer.second_trace = rsp_second_trace;
         seen_answer.second_value = rsp_second_value;
         seen_answer.position_error = rsp_position_error;
         sb.check_answer(seen_answer);
      end
   end

   // one request beat; returns at the falling edge after acceptance
   task automatic send_request(input logic [1:0] kind, input trace_id_type tsel,
                               input logic [INDEX_W-1:0] idx, input sample_type val);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_type = kind;
      req_trace_sel = tsel;
      req_index = idx;
      req_value = val;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(kind, tsel, idx, val);
      if (kind != REQ_UNUSED && !(kind == REQ_LOAD_CALL && idx >= CALL_DEPTH)) beats_sent++;
      @(negedge clock);
   endtask

   task automatic load_call(input int idx, input int pos);
      send_request(REQ_LOAD_CALL, trace_id_type'($urandom_range(3)), INDEX_W'(idx),
                   sample_type'(pos));
   endtask

   // wait until every answer is in and the block has gone quiet
   task automatic settle();
      start = 1'b0;
      while (sb.awaited_answers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.note_config(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_counts(input int samples, input int bases);
      settle();
      write_csr(CSR_SAMPLE_COUNT, CSR_DATA_W'(samples));
      write_csr(CSR_BASE_COUNT, CSR_DATA_W'(bases));
      settings_used++;
   endtask

   function automatic int random_position(int hi);
      if ($urandom_range(9) == 0) return $urandom_range(VALUE_LIMIT);
      return $urandom_range(hi);
   endfunction

   // load whatever a query at idx would read and has not been loaded yet
   task automatic fill_for_query(input int idx);
      int n, nb, hi, j, tr, k, c_addr, s_addr, e_addr;
      int addrs [3];
      n = sb.sample_limit();
      nb = sb.base_limit();
      if (nb != 0 && idx < nb) begin
         hi = (n > 0) ? n - 1 : 63;
         for (j = idx - 1; j <= idx + 1; j++)
            if (j >= 0 && j < nb && !sb.call_loaded[j]) load_call(j, random_position(hi));
         if (n > 0) begin
            sb.query_window(idx, c_addr, s_addr, e_addr);
            addrs[0] = sb.clip_addr(c_addr);
            addrs[1] = sb.clip_addr(s_addr);
            addrs[2] = sb.clip_addr(e_addr);
            for (k = 0; k < 3; k++)
               for (tr = 0; tr < TRACES; tr++)
                  if (!sb.trace_loaded[tr][addrs[k]])
                     send_request(REQ_LOAD_SAMPLE, trace_id_type'(tr), INDEX_W'(addrs[k]),
                                  sample_type'($urandom_range(VALUE_LIMIT)));
         end
      end
   endtask

   task automatic query_at(input int idx);
      fill_for_query(idx);
      send_request(REQ_QUERY, trace_id_type'($urandom_range(3)), INDEX_W'(idx),
                   sample_type'($urandom_range(VALUE_LIMIT)));
   endtask

   // neighbouring call: equal, on the wrong side, or on the usual side
   function automatic int neighbour_pos(int cur, int hi, int dir);
      int r, step, p;
      r = $urandom_range(99);
      step = $urandom_range(hi / 3 + 2, 1);
      if (r < 20) return cur;
      p = (r < 35) ? cur - dir * step : cur + dir * step;
      if (p < 0) p = 0;
      if (p > POS_LIMIT) p = POS_LIMIT;
      return p;
   endfunction

   // intensity, often from a few values so that ties come up
   function automatic int pick_level();
      if ($urandom_range(99) < 35) begin
         case ($urandom_range(3))
            0: return 0;
            1: return 1;
            2: return 32767;
            default: return VALUE_LIMIT;
         endcase
      end
      return $urandom_range(VALUE_LIMIT);
   endfunction

   // queried position: edges, just past the end, anywhere
   function automatic int pick_index();
      int nb, r;
      nb = sb.base_limit();
      r = $urandom_range(99);
      if (nb == 0 || r < 10) return $urandom_range(INDEX_LIMIT);
      if (r < 25) return 0;
      if (r < 40) return nb - 1;
      if (r < 48) return nb;
      return $urandom_range(nb - 1);
   endfunction

   // calls around idx, shaped samples in each trace, then the query
   task automatic peak_sequence(input int idx);
      int n, nb, hi, cur, tr, lvl, s_val, e_val, c_addr, s_addr, e_addr;
      bit is_peak;
      n = sb.sample_limit();
      nb = sb.base_limit();
      if (nb != 0 && idx < nb) begin
         hi = (n > 0) ? n - 1 : 63;
         cur = ($urandom_range(9) == 0) ? $urandom_range(POS_LIMIT) : $urandom_range(hi);
         if (idx > 0) load_call(idx - 1, neighbour_pos(cur, hi, -1));
         if (idx < nb - 1) load_call(idx + 1, neighbour_pos(cur, hi, 1));
         // over-wide position saturates to the top call position
         load_call(idx, (cur == POS_LIMIT && $urandom_range(1) == 1) ? VALUE_LIMIT : cur);
         if (n > 0) begin
            sb.query_window(idx, c_addr, s_addr, e_addr);
            c_addr = sb.clip_addr(c_addr);
            s_addr = sb.clip_addr(s_addr);
            e_addr = sb.clip_addr(e_addr);
            for (tr = 0; tr < TRACES; tr++) begin
               is_peak = ($urandom_range(99) < 65);
               lvl = pick_level();
               s_val = $urandom_range(lvl);
               e_val = $urandom_range(lvl);
               if (!is_peak && lvl < VALUE_LIMIT) begin
                  if ($urandom_range(1) == 1) s_val = $urandom_range(VALUE_LIMIT, lvl + 1);
                  else e_val = $urandom_range(VALUE_LIMIT, lvl + 1);
               end
               send_request(REQ_LOAD_SAMPLE, trace_id_type'(tr), INDEX_W'(s_addr),
                            sample_type'(s_val));
               send_request(REQ_LOAD_SAMPLE, trace_id_type'(tr), INDEX_W'(e_addr),
                            sample_type'(e_val));
               send_request(REQ_LOAD_SAMPLE, trace_id_type'(tr), INDEX_W'(c_addr),
                            sample_type'(lvl));
            end
         end
      end
      query_at(idx);
   endtask

   // random traffic under one register setting
   task automatic run_phase(input int samples, input int bases, input int idle);
      int first_beat, r, nb;
      set_counts(samples, bases);
      idle_pct = idle;
      first_beat = beats_sent;
      while (beats_sent - first_beat < PHASE_BEATS) begin
         r = $urandom_range(99);
         nb = sb.base_limit();
         if (r < 50) peak_sequence(pick_index());
         else if (r < 70) query_at(pick_index());
         else if (r < 85)
            send_request(REQ_LOAD_SAMPLE, trace_id_type'($urandom_range(3)),
                         INDEX_W'($urandom_range(INDEX_LIMIT)),
                         sample_type'($urandom_range(VALUE_LIMIT)));
         else if (r < 95)
            send_request(REQ_LOAD_CALL, trace_id_type'($urandom_range(3)),
                         INDEX_W'((nb > 0 && $urandom_range(4) != 0) ? $urandom_range(nb - 1)
                                  : $urandom_range(INDEX_LIMIT)),
                         sample_type'($urandom_range(VALUE_LIMIT)));
         else
            send_request(REQ_UNUSED, trace_id_type'($urandom_range(3)),
                         INDEX_W'($urandom_range(INDEX_LIMIT)),
                         sample_type'($urandom_range(VALUE_LIMIT)));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_LOAD_SAMPLE;
      req_trace_sel = '0;
      req_index = '0;
      req_value = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SAMPLE_COUNT;
      csr_data = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed: empty chromatogram and an unknown request code
      send_request(REQ_QUERY, trace_id_type'(0), INDEX_W'(0), sample_type'(0));
      send_request(REQ_UNUSED, trace_id_type'(3), INDEX_W'(INDEX_LIMIT),
                   sample_type'(VALUE_LIMIT));
      set_counts(16, 4);
      // position far out of range, base-call load past the table
      send_request(REQ_QUERY, trace_id_type'(3), INDEX_W'(INDEX_LIMIT), sample_type'(0));
      load_call(INDEX_LIMIT, 5);
      // over-wide call position at the first base, then both row edges
      load_call(0, VALUE_LIMIT);
      query_at(0);
      peak_sequence(3);
      peak_sequence(1);
      send_request(REQ_QUERY, trace_id_type'(0), INDEX_W'(4), sample_type'(0));
      // no valid samples: every read is zero
      set_counts(0, 4);
      query_at(2);

      // random phases, extremes among them
      run_phase(16, 4, 0);
      run_phase(1, 1, 74);
      settle();
      write_csr(CSR_SPARE_A, CSR_DATA_W'($urandom_range(32767)));
      write_csr(CSR_SPARE_B, '1);
      run_phase(64, 12, 0);
      run_phase(SAMPLE_DEPTH, CALL_DEPTH, 35);
      run_phase(32767, 32767, 0);
      run_phase(0, 3, 74);
      run_phase($urandom_range(200, 2), $urandom_range(40, 2), 35);
      run_phase($urandom_range(32767), $urandom_range(32767), 0);

      settle();
      sb.close_out();
      $display("ran %0d request beats under %0d register settings", beats_sent,
               settings_used);
      $display("checked %0d queries: %0d with a reported pair, %0d out of range",
               sb.queries, sb.pair_hits, sb.range_flags);
      if (sb.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/ctpf_pkg.sv
hdl/ctpf_ram.sv
hdl/ctpf_peak_select.sv
hdl/chromatogram_two_peak_finder.sv
hdl/ctpf_checker.sv
tb/sv/chromatogram_two_peak_finder_tb.sv
